/* design/tgb_pkg.sv */
`timescale 1ns / 1ps

package tgb_pkg;

    // Font store geometry
    localparam int MAX_GLYPH_ROWS = 16;
    localparam int GLYPH_COUNT    = 96;
    localparam int MAX_SCREEN     = 8192;
    localparam int MAX_GLYPH_COLS = 8;
    localparam int STORE_DEPTH    = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);

    // Printable range; anything else (but the null code) is drawn as a space
    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;
    localparam logic [7:0] CODE_NULL  = 8'd0;

    typedef enum logic [2:0] {
        REG_CHAR_WIDTH    = 3'd0,
        REG_CHAR_HEIGHT   = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_LINE_PITCH    = 3'd4,
        REG_FB_BASE       = 3'd5,
        REG_FORE_COLOR    = 3'd6,
        REG_BACK_COLOR    = 3'd7
    } reg_idx_t;

    typedef enum logic {
        KIND_DRAW = 1'b0,
        KIND_FONT = 1'b1
    } kind_t;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SETUP1 = 3'd1,
        ST_SETUP2 = 3'd2,
        ST_SETUP3 = 3'd3,
        ST_EMIT   = 3'd4,
        ST_ADV    = 3'd5
    } step_t;

    // Jump conditions
    typedef enum logic [1:0] {
        C_ALWAYS  = 2'd0,
        C_DRAW    = 2'd1,
        C_NO_ROWS = 2'd2,
        C_LAST    = 2'd3
    } cond_t;

    // Datapath strobes
    typedef struct packed {
        logic take_in;
        logic mul1;
        logic mul2;
        logic addr;
        logic emit;
        logic adv;
    } ctrl_t;

    // Status back from the datapath
    typedef struct packed {
        logic draw_go;
        logic no_rows;
        logic last_sent;
    } seq_flags_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t jump_to;
        step_t next_step;
    } uop_t;

    // Microcode ROM
    function automatic uop_t uop_rom(input step_t step);
        uop_t u;
        u = '{ctrl: '0, cond: C_ALWAYS, jump_to: ST_IDLE, next_step: ST_IDLE};
        case (step)
            ST_IDLE:
            begin
                u.ctrl.take_in = 1'b1;
                u.cond         = C_DRAW;
                u.jump_to      = ST_SETUP1;
                u.next_step    = ST_IDLE;
            end
            ST_SETUP1:
            begin
                u.ctrl.mul1 = 1'b1;
                u.cond      = C_ALWAYS;
                u.jump_to   = ST_SETUP2;
                u.next_step = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                u.ctrl.mul2 = 1'b1;
                u.cond      = C_ALWAYS;
                u.jump_to   = ST_SETUP3;
                u.next_step = ST_SETUP3;
            end
            ST_SETUP3:
            begin
                u.ctrl.addr = 1'b1;
                u.cond      = C_NO_ROWS;
                u.jump_to   = ST_ADV;
                u.next_step = ST_EMIT;
            end
            ST_EMIT:
            begin
                u.ctrl.emit = 1'b1;
                u.cond      = C_LAST;
                u.jump_to   = ST_ADV;
                u.next_step = ST_EMIT;
            end
            ST_ADV:
            begin
                u.ctrl.adv  = 1'b1;
                u.cond      = C_ALWAYS;
                u.jump_to   = ST_IDLE;
                u.next_step = ST_IDLE;
            end
            default:
            begin
                u.cond      = C_ALWAYS;
                u.jump_to   = ST_IDLE;
                u.next_step = ST_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

/* design/tgb_ram.sv */
`timescale 1ns / 1ps

module tgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/tgb_seq.sv */
`timescale 1ns / 1ps

module tgb_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tgb_pkg::seq_flags_t    flags,
    output tgb_pkg::ctrl_t         ctrl
);

    import tgb_pkg::*;

    step_t step_reg;
    step_t step_next;
    uop_t  uop;
    logic  taken;

    assign uop = uop_rom(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // next step
    always_comb
    begin
        case (uop.cond)
            C_ALWAYS:  taken = 1'b1;
            C_DRAW:    taken = flags.draw_go;
            C_NO_ROWS: taken = flags.no_rows;
            C_LAST:    taken = flags.last_sent;
            default:   taken = 1'b1;
        endcase
        step_next = taken ? uop.jump_to : uop.next_step;
    end

    // control word out
    always_comb
    begin
        ctrl = uop.ctrl;
    end

endmodule

/* design/text_glyph_blitter_top.sv */
`timescale 1ns / 1ps

// Text glyph blitter. Each input word is either a font write (kind 1: one byte
// into the 1536-entry font RAM, taken in the idle step) or a character to draw
// (kind 0). A drawn character yields one output word per visible glyph row:
// the row's byte address in a 32-bit-per-pixel framebuffer and up to eight
// pixel colors, with last_row set on the final word; the text cursor then
// advances, wrapping columns to the next row and rows back to the top. Code 0
// draws nothing; other codes outside 32..126 draw as a space. A draw passes
// through accept, three setup steps, an emit step that sends one row per
// cycle while the output side does not stall, and a cursor update; one row
// per cycle comes from the single font RAM read port. Items are worked one
// at a time under a small microcoded sequencer; the output register lets the
// next word be accepted while the last row still waits. The font RAM has no
// reset and must be written before glyphs that use it are drawn. Register
// writes on cfg_write/cfg_index/cfg_data take effect at once and must only
// happen while the block is idle.
module text_glyph_blitter_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  char_code,
    input  logic [10:0] font_index,
    input  logic [7:0]  font_byte,
    // output words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] row_address,
    output logic [3:0]  pixel_count,
    output logic [31:0] pixel_0,
    output logic [31:0] pixel_1,
    output logic [31:0] pixel_2,
    output logic [31:0] pixel_3,
    output logic [31:0] pixel_4,
    output logic [31:0] pixel_5,
    output logic [31:0] pixel_6,
    output logic [31:0] pixel_7,
    output logic        last_row
);

    import tgb_pkg::*;

    // ---------------- configuration registers ----------------
    logic [3:0]  char_width_reg;
    logic [4:0]  char_height_reg;
    logic [13:0] screen_width_reg;
    logic [13:0] screen_height_reg;
    logic [13:0] line_pitch_reg;
    logic [63:0] fb_base_reg;
    logic [31:0] fore_color_reg;
    logic [31:0] back_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_width_reg    <= 4'd8;
            char_height_reg   <= 5'd16;
            screen_width_reg  <= 14'd640;
            screen_height_reg <= 14'd480;
            line_pitch_reg    <= 14'd640;
            fb_base_reg       <= 64'd0;
            fore_color_reg    <= 32'h0000_FF00;
            back_color_reg    <= 32'h0000_00FF;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CHAR_WIDTH:    char_width_reg    <= cfg_data[3:0];
                REG_CHAR_HEIGHT:   char_height_reg   <= cfg_data[4:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[13:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[13:0];
                REG_LINE_PITCH:    line_pitch_reg    <= cfg_data[13:0];
                REG_FB_BASE:       fb_base_reg       <= cfg_data;
                REG_FORE_COLOR:    fore_color_reg    <= cfg_data[31:0];
                REG_BACK_COLOR:    back_color_reg    <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // Clamped geometry: width 1..8, height 1..16, screen 1..MAX_SCREEN
    logic [3:0]  cw;
    logic [4:0]  ch;
    logic [13:0] sw;
    logic [13:0] sh;

    always_comb
    begin
        if (char_width_reg == 4'd0)
            cw = 4'd1;
        else if (char_width_reg > 4'(MAX_GLYPH_COLS))
            cw = 4'(MAX_GLYPH_COLS);
        else
            cw = char_width_reg;

        if (char_height_reg == 5'd0)
            ch = 5'd1;
        else if (char_height_reg > 5'(MAX_GLYPH_ROWS))
            ch = 5'(MAX_GLYPH_ROWS);
        else
            ch = char_height_reg;

        if (screen_width_reg == 14'd0)
            sw = 14'd1;
        else if (screen_width_reg > 14'(MAX_SCREEN))
            sw = 14'(MAX_SCREEN);
        else
            sw = screen_width_reg;

        if (screen_height_reg == 14'd0)
            sh = 14'd1;
        else if (screen_height_reg > 14'(MAX_SCREEN))
            sh = 14'(MAX_SCREEN);
        else
            sh = screen_height_reg;
    end

    // ---------------- sequencer ----------------
    ctrl_t      ctrl;
    seq_flags_t flags;

    tgb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign in_ready = ctrl.take_in;

    logic in_fire;
    logic draw_go;
    logic font_we;

    assign in_fire = in_valid && in_ready;
    assign draw_go = in_fire && (kind_t'(kind) == KIND_DRAW) && (char_code != CODE_NULL);
    assign font_we = in_fire && (kind_t'(kind) == KIND_FONT) &&
                     ({1'b0, font_index} < 12'(STORE_DEPTH));

    // ---------------- datapath registers ----------------
    logic [6:0]          code_off_reg, code_off_next;   // code - 32
    logic [12:0]         cursor_col_reg, cursor_col_next;
    logic [12:0]         cursor_row_reg, cursor_row_next;
    logic [15:0]         sx_reg, sx_next;               // pixel x of the cell
    logic [16:0]         sy_reg, sy_next;               // pixel y of the cell
    logic [STORE_AW-1:0] ptr_reg, ptr_next;             // font RAM row pointer
    logic [30:0]         lin_reg, lin_next;             // sy * line_pitch
    logic [3:0]          cnt_reg, cnt_next;             // visible pixels per row
    logic [4:0]          rows_left_reg, rows_left_next;
    logic [63:0]         addr_reg, addr_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] row_address_reg;
    logic [3:0]  pixel_count_reg;
    logic [31:0] pixel_reg [MAX_GLYPH_COLS];
    logic        last_row_reg;

    logic [7:0]  glyph_bits;
    logic        out_free;
    logic        emit_fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = ctrl.emit && out_free;

    assign flags.draw_go   = draw_go;
    assign flags.no_rows   = (cnt_reg == 4'd0) || (rows_left_reg == 5'd0);
    assign flags.last_sent = emit_fire && (rows_left_reg == 5'd1);

    // clip terms
    logic [13:0] diff_x;
    logic [13:0] diff_y;
    // cursor update terms
    logic        wrap_col;
    logic        wrap_row;
    logic [13:0] col_inc;
    logic [13:0] row_inc;
    logic [5:0]  row_step;

    always_comb
    begin
        code_off_next   = code_off_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ptr_next        = ptr_reg;
        lin_next        = lin_reg;
        cnt_next        = cnt_reg;
        rows_left_next  = rows_left_reg;
        addr_next       = addr_reg;

        diff_x   = sw - sx_reg[13:0];
        diff_y   = sh - sy_reg[13:0];

        col_inc  = {1'b0, cursor_col_reg} + 14'd1;
        wrap_col = {4'b0, sw} < ({2'b0, sx_reg} + {13'b0, cw, 1'b0});
        row_inc  = {1'b0, cursor_row_reg} + {13'b0, wrap_col};
        row_step = wrap_col ? {ch, 1'b0} : {1'b0, ch};
        wrap_row = (row_inc != 14'd0) &&
                   ({5'b0, sh} < ({2'b0, sy_reg} + {13'b0, row_step}));

        if (draw_go)
        begin
            if (char_code inside {[CODE_FIRST:CODE_LAST]})
                code_off_next = 7'(char_code - CODE_FIRST);
            else
                code_off_next = 7'd0;
        end

        // cell origin and glyph base
        if (ctrl.mul1)
        begin
            sx_next  = {3'b0, cursor_col_reg} * {12'b0, cw};
            sy_next  = {4'b0, cursor_row_reg} * {12'b0, ch};
            ptr_next = {4'b0, code_off_reg} * {6'b0, ch};
        end

        // line offset and clipping
        if (ctrl.mul2)
        begin
            lin_next = {14'b0, sy_reg} * {17'b0, line_pitch_reg};
            if ({1'b0, sx_reg} >= {3'b0, sw})
                cnt_next = 4'd0;
            else if (diff_x < {10'b0, cw})
                cnt_next = diff_x[3:0];
            else
                cnt_next = cw;
            if (sy_reg >= {3'b0, sh})
                rows_left_next = 5'd0;
            else if (diff_y < {9'b0, ch})
                rows_left_next = diff_y[4:0];
            else
                rows_left_next = ch;
        end

        if (ctrl.addr)
        begin
            addr_next = fb_base_reg +
                        {30'b0, ({1'b0, lin_reg} + {16'b0, sx_reg}), 2'b00};
        end

        // one glyph row per fire; the next row's RAM read goes out alongside
        if (emit_fire)
        begin
            addr_next      = addr_reg + {48'b0, line_pitch_reg, 2'b00};
            rows_left_next = rows_left_reg - 5'd1;
            ptr_next       = ptr_reg + STORE_AW'(1);
        end

        if (ctrl.adv)
        begin
            cursor_col_next = wrap_col ? 13'd0 : col_inc[12:0];
            cursor_row_next = wrap_row ? 13'd0 : row_inc[12:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 13'd0;
            cursor_row_reg <= 13'd0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_off_reg  <= code_off_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        ptr_reg       <= ptr_next;
        lin_reg       <= lin_next;
        cnt_reg       <= cnt_next;
        rows_left_reg <= rows_left_next;
        addr_reg      <= addr_next;
    end

    // ---------------- font RAM ----------------
    // Read address is the pointer's next value, so read data always matches
    // ptr_reg, including while the output side stalls.
    tgb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_index[STORE_AW-1:0]),
        .wdata (font_byte),
        .raddr (ptr_next),
        .rdata (glyph_bits)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // MSB of the font byte is the leftmost pixel; unused slots read zero
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            row_address_reg <= addr_reg;
            pixel_count_reg <= cnt_reg;
            last_row_reg    <= (rows_left_reg == 5'd1);
            for (int i = 0; i < MAX_GLYPH_COLS; i++)
            begin
                if (4'(i) < cnt_reg)
                    pixel_reg[i] <= glyph_bits[MAX_GLYPH_COLS-1-i] ?
                                    fore_color_reg : back_color_reg;
                else
                    pixel_reg[i] <= 32'd0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_address = row_address_reg;
    assign pixel_count = pixel_count_reg;
    assign pixel_0     = pixel_reg[0];
    assign pixel_1     = pixel_reg[1];
    assign pixel_2     = pixel_reg[2];
    assign pixel_3     = pixel_reg[3];
    assign pixel_4     = pixel_reg[4];
    assign pixel_5     = pixel_reg[5];
    assign pixel_6     = pixel_reg[6];
    assign pixel_7     = pixel_reg[7];
    assign last_row    = last_row_reg;

    // ---------------- assertions ----------------
    // A new output word only appears right after a row step fired.
    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.emit))
        else $error("output word without a row step");

    // The cursor moves only in the advance step.
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.adv |=> $stable(cursor_col_reg) && $stable(cursor_row_reg))
        else $error("cursor moved outside the advance step");

    // While emitting, the row count is live and never above the glyph height.
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (rows_left_reg != 5'd0) && (rows_left_reg <= ch))
        else $error("row count out of range while emitting");

    // Input is never taken while a character is being worked.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.mul1 || ctrl.mul2 || ctrl.addr || ctrl.emit || ctrl.adv) |-> !in_ready)
        else $error("input taken while busy");

endmodule
